/* hw/rtl/stru_pkg.sv */
// Shared types, widths and codes of the spanning tree root update unit.
package stru_pkg;

   localparam int MAX_NODES_DEF = 16;
   localparam int ID_W          = 12;
   localparam int COST_W        = 8;
   localparam int IDXF_W        = 4;
   localparam int NCNT_W        = 5;
   localparam int MODE_W        = 2;
   localparam int STAT_W        = 3;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 12;

   localparam logic [NCNT_W-1:0] NODE_COUNT_RST  = NCNT_W'(16);
   localparam logic [COST_W-1:0] MAX_COST_RST    = COST_W'(255);
   localparam logic [ID_W-1:0]   MAX_NODE_ID_RST = ID_W'(4095);
   localparam logic [NCNT_W-1:0] UPD_CNT_MAX     = NCNT_W'(31);
   localparam logic [ID_W-1:0]   SUM_MAX         = ID_W'(4095);

   localparam logic [MODE_W-1:0] MODE_DEFINE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LINK   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_READ   = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
   localparam logic [STAT_W-1:0] ST_DUP_LINK  = 3'd1;
   localparam logic [STAT_W-1:0] ST_BAD_COST  = 3'd2;
   localparam logic [STAT_W-1:0] ST_BAD_ID    = 3'd3;
   localparam logic [STAT_W-1:0] ST_SELF_LINK = 3'd4;
   localparam logic [STAT_W-1:0] ST_BAD_INDEX = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_COST    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_NODE_ID = 2'd2;

   typedef struct packed {
      logic [ID_W-1:0] ident;
      logic [ID_W-1:0] root;
      logic [ID_W-1:0] hop;
      logic [ID_W-1:0] cost;
   } node_rec_type;

   typedef struct packed {
      logic capture;
      logic clear;
      logic latch;
      logic def_wr;
      logic link_ab;
      logic link_ba;
      logic cnt_inc;
      logic scan;
      logic me_wr;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic              clr_last;
      logic [MODE_W-1:0] mode;
      logic              bad;
      logic              def_ok;
      logic              link_ok;
      logic              scan_done;
      logic              out_free;
   } stat_type;

endpackage

/* hw/rtl/stru_ctrl.sv */
// Controller state machine of the spanning tree root update unit.
module stru_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  stru_pkg::stat_type stat,
   output stru_pkg::cmd_type  cmd
);
   import stru_pkg::*;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_LATCH = 3'd3;
   localparam logic [2:0] S_LINK  = 3'd4;
   localparam logic [2:0] S_SCAN  = 3'd5;
   localparam logic [2:0] S_WB    = 3'd6;
   localparam logic [2:0] S_OUT   = 3'd7;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_READ;
            end
         end
         S_READ: state_in = S_LATCH;
         S_LATCH: begin
            cmd.latch = 1'b1;
            state_in  = S_OUT;
            case (stat.mode)
               MODE_DEFINE: cmd.def_wr = stat.def_ok;
               MODE_LINK: begin
                  cmd.link_ab = stat.link_ok;
                  if (stat.link_ok) state_in = S_LINK;
               end
               MODE_UPDATE: begin
                  if (!stat.bad) begin
                     cmd.cnt_inc = 1'b1;
                     state_in    = S_SCAN;
                  end
               end
               default: state_in = S_OUT;
            endcase
         end
         S_LINK: begin
            cmd.link_ba = 1'b1;
            state_in    = S_OUT;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) state_in = S_WB;
         end
         S_WB: begin
            cmd.me_wr = 1'b1;
            state_in  = S_OUT;
         end
         S_OUT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else       state_ff <= state_in;
   end

endmodule

/* hw/rtl/stru_dp.sv */
// Datapath of the spanning tree root update unit: tables, link memory and result register.
module stru_dp #(
   parameter int MAX_NODES = stru_pkg::MAX_NODES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [stru_pkg::MODE_W-1:0]       req_mode,
   input  logic [stru_pkg::IDXF_W-1:0]       req_node_index,
   input  logic [stru_pkg::IDXF_W-1:0]       req_peer_index,
   input  logic [stru_pkg::ID_W-1:0]         req_new_id,
   input  logic [stru_pkg::COST_W-1:0]       req_link_cost,
   input  logic                              csr_we,
   input  logic [stru_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [stru_pkg::CSR_DATA_W-1:0]   csr_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [stru_pkg::STAT_W-1:0]       rsp_status,
   output logic [stru_pkg::ID_W-1:0]         rsp_own_id,
   output logic [stru_pkg::ID_W-1:0]         rsp_best_root,
   output logic [stru_pkg::ID_W-1:0]         rsp_via_hop,
   output logic [stru_pkg::ID_W-1:0]         rsp_root_cost,
   output logic                              rsp_tree_done,
   input  stru_pkg::cmd_type                  cmd,
   output stru_pkg::stat_type                 stat
);
   import stru_pkg::*;

   localparam int IDX_W   = $clog2(MAX_NODES);
   localparam int CNT_W   = $clog2(MAX_NODES + 1);
   localparam int NW      = (CNT_W > NCNT_W) ? CNT_W : NCNT_W;
   localparam int CDEPTH  = MAX_NODES * MAX_NODES;
   localparam int CADDR_W = $clog2(CDEPTH);

   // Captured item and configuration.
   logic [MODE_W-1:0] mode_ff;
   logic [IDXF_W-1:0] a_ff, b_ff;
   logic [ID_W-1:0]   nid_ff;
   logic [COST_W-1:0] lc_ff;
   logic [NCNT_W-1:0] node_count_ff;
   logic [COST_W-1:0] max_cost_ff;
   logic [ID_W-1:0]   max_node_id_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         a_ff    <= req_node_index;
         b_ff    <= req_peer_index;
         nid_ff  <= req_new_id;
         lc_ff   <= req_link_cost;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff  <= NODE_COUNT_RST;
         max_cost_ff    <= MAX_COST_RST;
         max_node_id_ff <= MAX_NODE_ID_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NODE_COUNT:  node_count_ff  <= csr_data[NCNT_W-1:0];
            CSR_MAX_COST:    max_cost_ff    <= csr_data[COST_W-1:0];
            CSR_MAX_NODE_ID: max_node_id_ff <= csr_data[ID_W-1:0];
            default: ;
         endcase
      end
   end

   logic [NW-1:0]      nc_ext, n_used, a_ext, b_ext;
   logic [IDX_W-1:0]   a_idx, b_idx;
   logic [CADDR_W-1:0] a_base, b_base;
   logic               bad;

   assign nc_ext = NW'(node_count_ff);
   assign n_used = (nc_ext > NW'(MAX_NODES)) ? NW'(MAX_NODES) : nc_ext;
   assign a_ext  = NW'(a_ff);
   assign b_ext  = NW'(b_ff);
   assign a_idx  = a_ext[IDX_W-1:0];
   assign b_idx  = b_ext[IDX_W-1:0];
   assign a_base = CADDR_W'(a_idx) * CADDR_W'(MAX_NODES);
   assign b_base = CADDR_W'(b_idx) * CADDR_W'(MAX_NODES);
   assign bad    = (a_ext >= n_used) || ((mode_ff == MODE_LINK) && (b_ext >= n_used));

   // Scan and clear counters.
   logic [NW-1:0]      scan_cnt_ff, scan_cnt_in;
   logic               eval_vld_ff;
   logic               scan_issue;
   logic [CADDR_W-1:0] clr_cnt_ff;

   assign scan_issue  = cmd.scan && (scan_cnt_ff < n_used);
   assign scan_cnt_in = cmd.latch ? '0 : (scan_issue ? scan_cnt_ff + NW'(1) : scan_cnt_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_cnt_ff <= '0;
         eval_vld_ff <= 1'b0;
         clr_cnt_ff  <= '0;
      end else begin
         scan_cnt_ff <= scan_cnt_in;
         eval_vld_ff <= scan_issue;
         if (cmd.clear) clr_cnt_ff <= clr_cnt_ff + CADDR_W'(1);
      end
   end

   // Link cost memory.
   logic [COST_W-1:0]  cost_mem [CDEPTH];
   logic [COST_W-1:0]  cost_rd_ff, cost_wd;
   logic [CADDR_W-1:0] cost_ra, cost_wa;
   logic               cost_we;

   assign cost_ra = cmd.scan ? a_base + CADDR_W'(scan_cnt_ff[IDX_W-1:0])
                             : a_base + CADDR_W'(b_idx);

   always_comb begin
      cost_we = 1'b1;
      cost_wa = clr_cnt_ff;
      cost_wd = '0;
      if (cmd.link_ab) begin
         cost_wa = a_base + CADDR_W'(b_idx);
         cost_wd = lc_ff;
      end else if (cmd.link_ba) begin
         cost_wa = b_base + CADDR_W'(a_idx);
         cost_wd = lc_ff;
      end else if (!cmd.clear) begin
         cost_we = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cost_we) cost_mem[cost_wa] <= cost_wd;
      cost_rd_ff <= cost_mem[cost_ra];
   end

   // Node record memory; an entry never written reads as zero.
   node_rec_type     node_mem [MAX_NODES];
   node_rec_type     node_rd_ff, node_rd, node_wd;
   logic [MAX_NODES-1:0] node_vld_ff;
   logic             node_rd_vld_ff, node_we;
   logic [IDX_W-1:0] node_ra;

   assign node_ra = cmd.scan ? scan_cnt_ff[IDX_W-1:0] : a_idx;
   assign node_rd = node_rd_vld_ff ? node_rd_ff : '0;
   assign node_we = cmd.def_wr || cmd.me_wr;

   node_rec_type w_ff, w_in;

   always_comb begin
      if (cmd.def_wr) node_wd = '{ident: nid_ff, root: nid_ff, hop: nid_ff, cost: node_rd.cost};
      else            node_wd = w_ff;
   end

   always_ff @(posedge clock) begin
      if (node_we) node_mem[a_idx] <= node_wd;
      node_rd_ff <= node_mem[node_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_vld_ff    <= '0;
         node_rd_vld_ff <= 1'b0;
      end else begin
         if (node_we) node_vld_ff[a_idx] <= 1'b1;
         node_rd_vld_ff <= node_vld_ff[node_ra];
      end
   end

   // Status checks, valid while the addressed record is on the read port.
   logic [STAT_W-1:0] st_in, st_ff;
   logic              id_bad;

   assign id_bad = (nid_ff == '0) || (nid_ff > max_node_id_ff);

   always_comb begin
      st_in = ST_OK;
      if (bad) st_in = ST_BAD_INDEX;
      else begin
         case (mode_ff)
            MODE_DEFINE: if (id_bad) st_in = ST_BAD_ID;
            MODE_LINK: begin
               if ((lc_ff == '0) || (lc_ff > max_cost_ff)) st_in = ST_BAD_COST;
               else if (a_ff == b_ff)                       st_in = ST_SELF_LINK;
               else if (cost_rd_ff != '0)                   st_in = ST_DUP_LINK;
            end
            default: st_in = ST_OK;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) st_ff <= st_in;
   end

   // Relaxation against one neighbor per cycle.
   logic [ID_W:0]   sum_wide;
   logic [ID_W-1:0] sum_sat;
   logic            nb_use;

   assign sum_wide = {1'b0, node_rd.cost} + (ID_W + 1)'(cost_rd_ff);
   assign sum_sat  = sum_wide[ID_W] ? SUM_MAX : sum_wide[ID_W-1:0];
   assign nb_use   = eval_vld_ff && (cost_rd_ff != '0) && (node_rd.ident != '0);

   always_comb begin
      w_in = w_ff;
      if (cmd.latch) begin
         w_in = cmd.def_wr ? node_wd : node_rd;
      end else if (nb_use) begin
         if (w_ff.root > node_rd.root) begin
            w_in.root = node_rd.root;
            w_in.hop  = node_rd.ident;
            w_in.cost = sum_sat;
         end else if ((w_ff.root == node_rd.root) && (w_ff.cost > sum_sat)) begin
            w_in.hop  = node_rd.ident;
            w_in.cost = sum_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
   end

   // Update counters and the tree-done check.
   logic [NCNT_W-1:0] upd_cnt_ff [MAX_NODES];
   logic              done;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_NODES; i++) upd_cnt_ff[i] <= '0;
      end else if (cmd.cnt_inc && (upd_cnt_ff[a_idx] < UPD_CNT_MAX)) begin
         upd_cnt_ff[a_idx] <= upd_cnt_ff[a_idx] + NCNT_W'(1);
      end
   end

   always_comb begin
      done = 1'b1;
      for (int i = 0; i < MAX_NODES; i++) begin
         if ((NW'(i) < n_used) && (upd_cnt_ff[i] < node_count_ff)) done = 1'b0;
      end
   end

   // Result register.
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.out_load) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_status    <= st_ff;
         rsp_own_id    <= bad ? '0 : w_ff.ident;
         rsp_best_root <= bad ? '0 : w_ff.root;
         rsp_via_hop   <= bad ? '0 : w_ff.hop;
         rsp_root_cost <= bad ? '0 : w_ff.cost;
         rsp_tree_done <= done;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   assign stat.clr_last  = (clr_cnt_ff == CADDR_W'(CDEPTH - 1));
   assign stat.mode      = mode_ff;
   assign stat.bad       = bad;
   assign stat.def_ok    = !bad && !id_bad && (node_rd.ident == '0);
   assign stat.link_ok   = (mode_ff == MODE_LINK) && (st_in == ST_OK);
   assign stat.scan_done = !(scan_cnt_ff < n_used) && !eval_vld_ff;
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

endmodule

/* hw/rtl/spanning_tree_root_update_unit.sv */
// Top level of the spanning tree root update unit.
//
// Each transfer on the req_ channel is one item and gives exactly one transfer
// on the rsp_ channel; items are handled one at a time. A node define, a read
// or a rejected item passes through the read, latch and output states before
// its result is registered, and the next item is taken once that result is
// loaded. A link define adds the link state, because the cost is written in
// both directions one after the other. An accepted update adds the neighbor
// scan, which reads one link cost and one neighbor record per cycle from the
// two memories for each of the N nodes in use (N is the node count, at most
// MAX_NODES), then drains the read pipeline and writes the record back. While
// an earlier result still waits on rsp_ready the next result is held back and
// the input stays closed. After reset the link cost memory is cleared one entry
// per cycle over all MAX_NODES*MAX_NODES entries (256 at the default), and
// req_ready stays low until that pass ends; configuration writes are taken at
// any time and must be issued only while the block is idle.
module spanning_tree_root_update_unit #(
   parameter int MAX_NODES = stru_pkg::MAX_NODES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [stru_pkg::MODE_W-1:0]       req_mode,
   input  logic [stru_pkg::IDXF_W-1:0]       req_node_index,
   input  logic [stru_pkg::IDXF_W-1:0]       req_peer_index,
   input  logic [stru_pkg::ID_W-1:0]         req_new_id,
   input  logic [stru_pkg::COST_W-1:0]       req_link_cost,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [stru_pkg::STAT_W-1:0]       rsp_status,
   output logic [stru_pkg::ID_W-1:0]         rsp_own_id,
   output logic [stru_pkg::ID_W-1:0]         rsp_best_root,
   output logic [stru_pkg::ID_W-1:0]         rsp_via_hop,
   output logic [stru_pkg::ID_W-1:0]         rsp_root_cost,
   output logic                              rsp_tree_done,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [stru_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [stru_pkg::CSR_DATA_W-1:0]   csr_data
);
   import stru_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Configuration registers accept a write in every cycle.
   assign csr_ready = 1'b1;

   // The controller sequences each item; the datapath holds every table.
   stru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   stru_dp #(.MAX_NODES(MAX_NODES)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_mode       (req_mode),
      .req_node_index (req_node_index),
      .req_peer_index (req_peer_index),
      .req_new_id     (req_new_id),
      .req_link_cost  (req_link_cost),
      .csr_we         (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_own_id     (rsp_own_id),
      .rsp_best_root  (rsp_best_root),
      .rsp_via_hop    (rsp_via_hop),
      .rsp_root_cost  (rsp_root_cost),
      .rsp_tree_done  (rsp_tree_done),
      .cmd            (cmd),
      .stat           (stat)
   );

endmodule

/* hw/rtl/stru_checker.sv */
// Port-level assertions of the spanning tree root update unit and their bind.
module stru_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [stru_pkg::STAT_W-1:0]       rsp_status,
   input logic [stru_pkg::ID_W-1:0]         rsp_own_id,
   input logic [stru_pkg::ID_W-1:0]         rsp_best_root,
   input logic [stru_pkg::ID_W-1:0]         rsp_via_hop,
   input logic [stru_pkg::ID_W-1:0]         rsp_root_cost
);
   import stru_pkg::*;

   // The clearing pass keeps the input side closed right after reset.
   a_clear_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !req_ready && !rsp_valid)
      else $error("req_ready or rsp_valid high right after reset");

   // A stalled result holds its valid, status and own ID.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_own_id))
      else $error("stalled result changed");

   // A bad index result carries no node state.
   a_bad_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_BAD_INDEX) |->
         (rsp_own_id == '0) && (rsp_best_root == '0) && (rsp_via_hop == '0) &&
         (rsp_root_cost == '0))
      else $error("bad index result with nonzero state");

   // An item taken cannot have its result show in the very next cycle.
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result appeared one cycle after transfer");

endmodule

bind spanning_tree_root_update_unit stru_checker u_stru_checker (.*);
